// ===== design/ata_taskfile_command_setup_unit_defines.svh =====
// assertion macros for the ata taskfile command setup unit
// used by the port checker, no other dependencies
`ifndef ATA_TASKFILE_COMMAND_SETUP_UNIT_DEFINES_SVH
`define ATA_TASKFILE_COMMAND_SETUP_UNIT_DEFINES_SVH

// same-cycle implication
`define ATACS_ASSERT_IMM(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ATACS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/atacs_pkg.sv =====
// types and constants of the ata taskfile command setup unit
// no dependencies
package atacs_pkg;

    localparam int LBA_W   = 48;
    localparam int COUNT_W = 16;
    localparam int STEP_W  = 4;

    typedef enum logic [2:0] {
        OUT_OK        = 3'd0,
        OUT_BAD_ARGS  = 3'd1,
        OUT_NO_DEV    = 3'd2,
        OUT_PROTECTED = 3'd3,
        OUT_RANGE     = 3'd4
    } t_outcome;

    typedef enum logic [2:0] {
        REG_NONE    = 3'd0,
        REG_COUNT   = 3'd2,
        REG_LBA_LO  = 3'd3,
        REG_LBA_MID = 3'd4,
        REG_LBA_HI  = 3'd5,
        REG_DRVHEAD = 3'd6,
        REG_CMD     = 3'd7
    } t_reg_off;

    typedef enum logic [2:0] {
        CFG_DEVICE_PRESENT  = 3'd0,
        CFG_LONG_ADDRESSING = 3'd1,
        CFG_SECONDARY_DRIVE = 3'd2,
        CFG_CAPACITY        = 3'd3,
        CFG_PROTECTED_LIMIT = 3'd4
    } t_cfg_idx;

    localparam logic [LBA_W-1:0]   PROTECT_RESET   = 48'd400;
    localparam logic [COUNT_W-1:0] COUNT28_MAX     = 16'd256;
    localparam logic [7:0]         DH_LBA28        = 8'hE0;
    localparam logic [7:0]         DH_LBA48        = 8'h40;
    localparam logic [7:0]         DH_SLAVE        = 8'h10;
    localparam logic [STEP_W-1:0]  LONG_LAST_STEP  = 4'd9;
    localparam logic [STEP_W-1:0]  SHORT_LAST_STEP = 4'd5;

    typedef struct packed {
        logic               is_write;
        logic [LBA_W-1:0]   start_sector;
        logic [COUNT_W-1:0] sector_count;
        logic [7:0]         short_command;
        logic [7:0]         long_command;
    } t_req;

    typedef struct packed {
        t_reg_off   reg_offset;
        logic [7:0] reg_value;
        logic       settle_after;
        t_outcome   outcome;
        logic       last;
    } t_rsp;

endpackage

// ===== design/ata_taskfile_command_setup_unit.sv =====
// the first word of a request passes through the job stage and then the output register
// one word per cycle while the receiver is ready; a request gives 1 (refused), 6 (lba28)
// or 10 (lba48) words, which leave through the single output register
// a new request is taken in the cycle its predecessor's last word is issued
// reset (synchronous, active low) empties both stages and restores configuration defaults
module ata_taskfile_command_setup_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [47:0]       i_cfg_wdata,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  atacs_pkg::t_req   i_req,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output atacs_pkg::t_rsp   o_rsp
);

    logic                                r_device_present;
    logic                                r_long_addressing;
    logic                                r_secondary_drive;
    logic [atacs_pkg::LBA_W-1:0]         r_capacity;
    logic [atacs_pkg::LBA_W-1:0]         r_protected_limit;

    logic                                r_job_valid;
    atacs_pkg::t_outcome                 r_code;
    logic                                r_long;
    logic [atacs_pkg::STEP_W-1:0]        r_step;
    logic [atacs_pkg::LBA_W-1:0]         r_lba;
    logic [atacs_pkg::COUNT_W-1:0]       r_cnt;
    logic [7:0]                          r_cmd;
    logic                                r_slave;

    logic                                r_out_valid;
    atacs_pkg::t_rsp                     r_out;

    atacs_pkg::t_outcome                 n_code;
    logic                                big;
    logic [atacs_pkg::LBA_W:0]           end_sector;
    logic                                take_in;
    logic                                load_out;
    logic                                job_done;
    atacs_pkg::t_rsp                     n_word;
    logic [7:0]                          dh_slave;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_present  <= 1'b0;
            r_long_addressing <= 1'b0;
            r_secondary_drive <= 1'b0;
            r_capacity        <= '0;
            r_protected_limit <= atacs_pkg::PROTECT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                atacs_pkg::CFG_DEVICE_PRESENT:  r_device_present  <= i_cfg_wdata[0];
                atacs_pkg::CFG_LONG_ADDRESSING: r_long_addressing <= i_cfg_wdata[0];
                atacs_pkg::CFG_SECONDARY_DRIVE: r_secondary_drive <= i_cfg_wdata[0];
                atacs_pkg::CFG_CAPACITY:        r_capacity        <= i_cfg_wdata;
                atacs_pkg::CFG_PROTECTED_LIMIT: r_protected_limit <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // request checks
    always_comb begin
        big = (i_req.start_sector[atacs_pkg::LBA_W-1:28] != '0)
            || (i_req.sector_count > atacs_pkg::COUNT28_MAX);
        end_sector = {1'b0, i_req.start_sector}
            + {{(atacs_pkg::LBA_W + 1 - atacs_pkg::COUNT_W){1'b0}}, i_req.sector_count};
        if (i_req.sector_count == '0) begin
            n_code = atacs_pkg::OUT_BAD_ARGS;
        end else if (!r_device_present) begin
            n_code = atacs_pkg::OUT_NO_DEV;
        end else if (i_req.is_write && (i_req.start_sector < r_protected_limit)) begin
            n_code = atacs_pkg::OUT_PROTECTED;
        end else if (end_sector > {1'b0, r_capacity}) begin
            n_code = atacs_pkg::OUT_RANGE;
        end else if (!r_long_addressing && big) begin
            n_code = atacs_pkg::OUT_BAD_ARGS;
        end else begin
            n_code = atacs_pkg::OUT_OK;
        end
    end

    // word generation
    always_comb begin
        dh_slave            = r_slave ? atacs_pkg::DH_SLAVE : 8'h00;
        n_word.reg_offset   = atacs_pkg::REG_NONE;
        n_word.reg_value    = 8'h00;
        n_word.settle_after = 1'b0;
        n_word.outcome      = r_code;
        n_word.last         = 1'b0;
        if (r_code != atacs_pkg::OUT_OK) begin
            n_word.last = 1'b1;
        end else if (r_long) begin
            unique case (r_step)
                4'd0: begin
                    n_word.reg_offset   = atacs_pkg::REG_DRVHEAD;
                    n_word.reg_value    = atacs_pkg::DH_LBA48 | dh_slave;
                    n_word.settle_after = 1'b1;
                end
                4'd1: begin
                    n_word.reg_offset = atacs_pkg::REG_COUNT;
                    n_word.reg_value  = r_cnt[15:8];
                end
                4'd2: begin
                    n_word.reg_offset = atacs_pkg::REG_LBA_LO;
                    n_word.reg_value  = r_lba[31:24];
                end
                4'd3: begin
                    n_word.reg_offset = atacs_pkg::REG_LBA_MID;
                    n_word.reg_value  = r_lba[39:32];
                end
                4'd4: begin
                    n_word.reg_offset = atacs_pkg::REG_LBA_HI;
                    n_word.reg_value  = r_lba[47:40];
                end
                4'd5: begin
                    n_word.reg_offset = atacs_pkg::REG_COUNT;
                    n_word.reg_value  = r_cnt[7:0];
                end
                4'd6: begin
                    n_word.reg_offset = atacs_pkg::REG_LBA_LO;
                    n_word.reg_value  = r_lba[7:0];
                end
                4'd7: begin
                    n_word.reg_offset = atacs_pkg::REG_LBA_MID;
                    n_word.reg_value  = r_lba[15:8];
                end
                4'd8: begin
                    n_word.reg_offset = atacs_pkg::REG_LBA_HI;
                    n_word.reg_value  = r_lba[23:16];
                end
                default: begin
                    n_word.reg_offset = atacs_pkg::REG_CMD;
                    n_word.reg_value  = r_cmd;
                    n_word.last       = 1'b1;
                end
            endcase
        end else begin
            unique case (r_step)
                4'd0: begin
                    n_word.reg_offset   = atacs_pkg::REG_DRVHEAD;
                    n_word.reg_value    = atacs_pkg::DH_LBA28 | dh_slave
                                        | {4'h0, r_lba[27:24]};
                    n_word.settle_after = 1'b1;
                end
                4'd1: begin
                    n_word.reg_offset = atacs_pkg::REG_COUNT;
                    n_word.reg_value  = r_cnt[7:0];
                end
                4'd2: begin
                    n_word.reg_offset = atacs_pkg::REG_LBA_LO;
                    n_word.reg_value  = r_lba[7:0];
                end
                4'd3: begin
                    n_word.reg_offset = atacs_pkg::REG_LBA_MID;
                    n_word.reg_value  = r_lba[15:8];
                end
                4'd4: begin
                    n_word.reg_offset = atacs_pkg::REG_LBA_HI;
                    n_word.reg_value  = r_lba[23:16];
                end
                default: begin
                    n_word.reg_offset = atacs_pkg::REG_CMD;
                    n_word.reg_value  = r_cmd;
                    n_word.last       = 1'b1;
                end
            endcase
        end
    end

    assign load_out    = r_job_valid && (!r_out_valid || i_rsp_ready);
    assign job_done    = load_out && n_word.last;
    assign o_req_ready = !r_job_valid || job_done;
    assign take_in     = i_req_valid && o_req_ready;

    // job stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_step      <= '0;
        end else if (take_in) begin
            r_job_valid <= 1'b1;
            r_step      <= '0;
        end else if (job_done) begin
            r_job_valid <= 1'b0;
        end else if (load_out) begin
            r_step <= r_step + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_code  <= n_code;
            r_long  <= big;
            r_lba   <= i_req.start_sector;
            r_cnt   <= i_req.sector_count;
            r_cmd   <= big ? i_req.long_command : i_req.short_command;
            r_slave <= r_secondary_drive;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= n_word;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

// ===== design/atacs_checker.sv =====
// port checker for the ata taskfile command setup unit, bound to the top level
// depends on atacs_pkg and ata_taskfile_command_setup_unit_defines.svh
`include "ata_taskfile_command_setup_unit_defines.svh"

module atacs_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_rsp_valid,
    input logic            i_rsp_ready,
    input atacs_pkg::t_rsp i_rsp
);

    `ATACS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp), "stalled word changed")
    `ATACS_ASSERT_IMM(a_refuse, i_clk, i_rst_n, i_rsp_valid && (i_rsp.outcome != atacs_pkg::OUT_OK), i_rsp.last && (i_rsp.reg_offset == atacs_pkg::REG_NONE) && (i_rsp.reg_value == 8'h00) && !i_rsp.settle_after, "refusal word not a lone zero word")
    `ATACS_ASSERT_IMM(a_settle, i_clk, i_rst_n, i_rsp_valid && i_rsp.settle_after, (i_rsp.reg_offset == atacs_pkg::REG_DRVHEAD) && (i_rsp.outcome == atacs_pkg::OUT_OK), "settle outside drive/head write")
    `ATACS_ASSERT_IMM(a_last_cmd, i_clk, i_rst_n, i_rsp_valid && i_rsp.last && (i_rsp.outcome == atacs_pkg::OUT_OK), i_rsp.reg_offset == atacs_pkg::REG_CMD, "accepted request not ended by command")
    `ATACS_ASSERT_NEXT(a_after_last, i_clk, i_rst_n, i_rsp_valid && i_rsp_ready && i_rsp.last, !i_rsp_valid || (i_rsp.outcome != atacs_pkg::OUT_OK) || (i_rsp.reg_offset == atacs_pkg::REG_DRVHEAD), "request did not open with drive/head")

endmodule

bind ata_taskfile_command_setup_unit atacs_checker u_atacs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp_valid),
    .i_rsp_ready (i_rsp_ready),
    .i_rsp       (o_rsp)
);

// ===== test/ata_taskfile_command_setup_unit_tb.sv =====
// self-checking testbench for the ata taskfile command setup unit
// predicts taskfile writes from the request and register settings, or a typed row
// depends on atacs_pkg and the ata_taskfile_command_setup_unit design
module ata_taskfile_command_setup_unit_tb;

    localparam int LBA_W   = atacs_pkg::LBA_W;
    localparam int COUNT_W = atacs_pkg::COUNT_W;

    localparam logic [LBA_W-1:0] LBA_MAX     = '1;
    localparam logic [LBA_W-1:0] LBA28_LIMIT = 48'h0000_0FFF_FFFF;
    localparam int NUM_DIR         = 24;
    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 17;
    localparam int HOLD_PHASE      = 2;
    localparam int PAUSE_PHASE     = 5;
    localparam int RX_HOLD_CYCLES  = 200;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = 30;

    typedef struct packed {
        logic             present;
        logic             long_addr;
        logic             secondary;
        logic [LBA_W-1:0] capacity;
        logic [LBA_W-1:0] plimit;
    } t_cfg;

    typedef struct packed {
        logic [2:0]          phase;
        atacs_pkg::t_req     req;
        logic                typed;
        atacs_pkg::t_outcome outcome;
    } t_dir_row;

    localparam t_cfg DIR_CFG [0:4] = '{
        '{1'b0, 1'b0, 1'b0, 48'd0,   atacs_pkg::PROTECT_RESET},
        '{1'b1, 1'b0, 1'b0, LBA_MAX, 48'd400},
        '{1'b1, 1'b1, 1'b1, LBA_MAX, 48'd0},
        '{1'b1, 1'b1, 1'b0, 48'd0,   LBA_MAX},
        '{1'b0, 1'b1, 1'b1, LBA_MAX, 48'd0}
    };

    localparam t_dir_row DIR_ROWS [0:NUM_DIR-1] = '{
        '{3'd0, '{1'b0, 48'd0, 16'd0, 8'h20, 8'h24}, 1'b1, atacs_pkg::OUT_BAD_ARGS},
        '{3'd0, '{1'b0, 48'd5, 16'd1, 8'h20, 8'h24}, 1'b1, atacs_pkg::OUT_NO_DEV},
        '{3'd0, '{1'b1, LBA_MAX, 16'hFFFF, 8'h30, 8'h34}, 1'b1, atacs_pkg::OUT_NO_DEV},
        '{3'd1, '{1'b1, 48'd399, 16'd1, 8'h30, 8'h34}, 1'b1, atacs_pkg::OUT_PROTECTED},
        '{3'd1, '{1'b1, 48'd400, 16'd1, 8'h30, 8'h34}, 1'b0, atacs_pkg::OUT_OK},
        '{3'd1, '{1'b0, 48'd0, 16'd256, 8'h20, 8'h24}, 1'b0, atacs_pkg::OUT_OK},
        '{3'd1, '{1'b0, 48'd0, 16'd257, 8'h20, 8'h24}, 1'b1, atacs_pkg::OUT_BAD_ARGS},
        '{3'd1, '{1'b0, LBA28_LIMIT, 16'd1, 8'h00, 8'hFF}, 1'b0, atacs_pkg::OUT_OK},
        '{3'd1, '{1'b0, 48'h1000_0000, 16'd1, 8'h20, 8'h24}, 1'b1, atacs_pkg::OUT_BAD_ARGS},
        '{3'd1, '{1'b0, LBA_MAX, 16'd1, 8'h20, 8'h24}, 1'b1, atacs_pkg::OUT_RANGE},
        '{3'd1, '{1'b1, 48'd0, 16'd0, 8'h30, 8'h34}, 1'b1, atacs_pkg::OUT_BAD_ARGS},
        '{3'd2, '{1'b1, 48'd0, 16'd1, 8'h30, 8'h34}, 1'b0, atacs_pkg::OUT_OK},
        '{3'd2, '{1'b0, 48'h1000_0000, 16'd1, 8'h20, 8'h24}, 1'b0, atacs_pkg::OUT_OK},
        '{3'd2, '{1'b0, 48'd0, 16'd257, 8'h20, 8'h24}, 1'b0, atacs_pkg::OUT_OK},
        '{3'd2, '{1'b0, LBA_MAX - 48'hFFFF, 16'hFFFF, 8'hFF, 8'h00}, 1'b0, atacs_pkg::OUT_OK},
        '{3'd2, '{1'b1, 48'h1234_5678_9ABC, 16'h1234, 8'h30, 8'h34}, 1'b0, atacs_pkg::OUT_OK},
        '{3'd2, '{1'b0, LBA28_LIMIT, 16'd256, 8'hC4, 8'h29}, 1'b0, atacs_pkg::OUT_OK},
        '{3'd2, '{1'b0, LBA_MAX, 16'd1, 8'h20, 8'h24}, 1'b1, atacs_pkg::OUT_RANGE},
        '{3'd3, '{1'b0, 48'd0, 16'd1, 8'h20, 8'h24}, 1'b1, atacs_pkg::OUT_RANGE},
        '{3'd3, '{1'b1, LBA_MAX - 48'd1, 16'd1, 8'h30, 8'h34}, 1'b1, atacs_pkg::OUT_PROTECTED},
        '{3'd3, '{1'b1, LBA_MAX, 16'd1, 8'h30, 8'h34}, 1'b1, atacs_pkg::OUT_RANGE},
        '{3'd3, '{1'b0, 48'd0, 16'd0, 8'h20, 8'h24}, 1'b1, atacs_pkg::OUT_BAD_ARGS},
        '{3'd4, '{1'b0, 48'd0, 16'd1, 8'h20, 8'h24}, 1'b1, atacs_pkg::OUT_NO_DEV},
        '{3'd4, '{1'b1, 48'h5A5A_5A5A_5A5A, 16'hA5A5, 8'h30, 8'h34}, 1'b1,
          atacs_pkg::OUT_NO_DEV}
    };

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [2:0]       i_cfg_idx;
    logic [LBA_W-1:0] i_cfg_wdata;
    logic             i_req_valid;
    logic             o_req_ready;
    atacs_pkg::t_req  i_req;
    logic             o_rsp_valid;
    logic             i_rsp_ready;
    atacs_pkg::t_rsp  o_rsp;

    t_cfg cfg = DIR_CFG[0];
    atacs_pkg::t_rsp expected_tf_writes [$];
    logic tail_mode   = 1'b0;
    logic rx_hold_req = 1'b0;
    int   err_count   = 0;
    int   word_count  = 0;
    int   req_count   = 0;
    int   cfg_count   = 0;

    ata_taskfile_command_setup_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic void note_error(input string msg);
        err_count++;
        if (err_count <= 10) begin
            $display("%s", msg);
        end
    endfunction

    function automatic void queue_write(input atacs_pkg::t_reg_off off,
                                        input logic [7:0] val,
                                        input logic settle, input atacs_pkg::t_outcome oc,
                                        input logic last);
        atacs_pkg::t_rsp w;
        w.reg_offset   = off;
        w.reg_value    = val;
        w.settle_after = settle;
        w.outcome      = oc;
        w.last         = last;
        expected_tf_writes.push_back(w);
    endfunction

    function automatic void predict_taskfile(input atacs_pkg::t_req r);
        logic [LBA_W:0]      end_sector;
        logic                wide;
        logic [7:0]          slave;
        atacs_pkg::t_outcome verdict;
        end_sector = {1'b0, r.start_sector}
                   + {{(LBA_W + 1 - COUNT_W){1'b0}}, r.sector_count};
        wide       = (r.start_sector > LBA28_LIMIT)
                   || (r.sector_count > atacs_pkg::COUNT28_MAX);
        slave      = cfg.secondary ? atacs_pkg::DH_SLAVE : 8'h00;
        verdict    = atacs_pkg::OUT_OK;
        if (r.sector_count == '0) begin
            verdict = atacs_pkg::OUT_BAD_ARGS;
        end else if (!cfg.present) begin
            verdict = atacs_pkg::OUT_NO_DEV;
        end else if (r.is_write && r.start_sector < cfg.plimit) begin
            verdict = atacs_pkg::OUT_PROTECTED;
        end else if (end_sector > {1'b0, cfg.capacity}) begin
            verdict = atacs_pkg::OUT_RANGE;
        end else if (!cfg.long_addr && wide) begin
            verdict = atacs_pkg::OUT_BAD_ARGS;
        end
        if (verdict != atacs_pkg::OUT_OK) begin
            queue_write(atacs_pkg::REG_NONE, 8'h00, 1'b0, verdict, 1'b1);
        end else if (cfg.long_addr && wide) begin
            queue_write(atacs_pkg::REG_DRVHEAD, atacs_pkg::DH_LBA48 | slave,
                        1'b1, atacs_pkg::OUT_OK, 1'b0);
            queue_write(atacs_pkg::REG_COUNT, r.sector_count[15:8],
                        1'b0, atacs_pkg::OUT_OK, 1'b0);
            queue_write(atacs_pkg::REG_LBA_LO, r.start_sector[31:24],
                        1'b0, atacs_pkg::OUT_OK, 1'b0);
            queue_write(atacs_pkg::REG_LBA_MID, r.start_sector[39:32],
                        1'b0, atacs_pkg::OUT_OK, 1'b0);
            queue_write(atacs_pkg::REG_LBA_HI, r.start_sector[47:40],
                        1'b0, atacs_pkg::OUT_OK, 1'b0);
            queue_write(atacs_pkg::REG_COUNT, r.sector_count[7:0],
                        1'b0, atacs_pkg::OUT_OK, 1'b0);
            queue_write(atacs_pkg::REG_LBA_LO, r.start_sector[7:0],
                        1'b0, atacs_pkg::OUT_OK, 1'b0);
            queue_write(atacs_pkg::REG_LBA_MID, r.start_sector[15:8],
                        1'b0, atacs_pkg::OUT_OK, 1'b0);
            queue_write(atacs_pkg::REG_LBA_HI, r.start_sector[23:16],
                        1'b0, atacs_pkg::OUT_OK, 1'b0);
            queue_write(atacs_pkg::REG_CMD, r.long_command,
                        1'b0, atacs_pkg::OUT_OK, 1'b1);
        end else begin
            queue_write(atacs_pkg::REG_DRVHEAD,
                        atacs_pkg::DH_LBA28 | slave | {4'h0, r.start_sector[27:24]},
                        1'b1, atacs_pkg::OUT_OK, 1'b0);
            queue_write(atacs_pkg::REG_COUNT, r.sector_count[7:0],
                        1'b0, atacs_pkg::OUT_OK, 1'b0);
            queue_write(atacs_pkg::REG_LBA_LO, r.start_sector[7:0],
                        1'b0, atacs_pkg::OUT_OK, 1'b0);
            queue_write(atacs_pkg::REG_LBA_MID, r.start_sector[15:8],
                        1'b0, atacs_pkg::OUT_OK, 1'b0);
            queue_write(atacs_pkg::REG_LBA_HI, r.start_sector[23:16],
                        1'b0, atacs_pkg::OUT_OK, 1'b0);
            queue_write(atacs_pkg::REG_CMD, r.short_command,
                        1'b0, atacs_pkg::OUT_OK, 1'b1);
        end
    endfunction

    function automatic logic [LBA_W-1:0] rand48();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[LBA_W-1:0];
    endfunction

    function automatic logic [LBA_W-1:0] pick_between(input logic [LBA_W-1:0] lo,
                                                     input logic [LBA_W-1:0] hi);
        logic [63:0]    raw;
        logic [LBA_W:0] span;
        raw  = {$urandom, $urandom};
        span = {1'b0, hi} - {1'b0, lo} + {{LBA_W{1'b0}}, 1'b1};
        return lo + LBA_W'(raw % span);
    endfunction

    function automatic t_cfg rand_cfg();
        t_cfg c;
        c.present   = ($urandom_range(0, 9) != 0);
        c.long_addr = 1'($urandom_range(0, 1));
        c.secondary = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: c.capacity = LBA_MAX;
            1: c.capacity = rand48();
            2: c.capacity = LBA28_LIMIT + 48'd1;
            default: c.capacity = LBA_W'($urandom_range(0, 5000));
        endcase
        case ($urandom_range(0, 3))
            0: c.plimit = '0;
            1: c.plimit = LBA_W'($urandom_range(0, 1000));
            2: c.plimit = rand48();
            default: c.plimit = atacs_pkg::PROTECT_RESET;
        endcase
        return c;
    endfunction

    // mostly requests that fit the current drive, the rest is noise
    function automatic atacs_pkg::t_req rand_req();
        atacs_pkg::t_req  r;
        logic [LBA_W-1:0] lo;
        logic [LBA_W-1:0] hi;
        logic [LBA_W-1:0] cnt_ext;
        int               sel;
        r.is_write      = 1'($urandom_range(0, 1));
        r.short_command = 8'($urandom_range(0, 255));
        r.long_command  = 8'($urandom_range(0, 255));
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
            r.sector_count = COUNT_W'($urandom_range(1, 256));
        end else if (sel < 9) begin
            r.sector_count = COUNT_W'($urandom_range(257, 65535));
        end else begin
            r.sector_count = COUNT_W'($urandom_range(0, 65535));
        end
        cnt_ext = {{(LBA_W - COUNT_W){1'b0}}, r.sector_count};
        if ($urandom_range(0, 3) != 0 && cfg.capacity >= cnt_ext) begin
            hi = cfg.capacity - cnt_ext;
            lo = (r.is_write && cfg.plimit <= hi) ? cfg.plimit : '0;
            if ($urandom_range(0, 1) == 1 && hi > LBA28_LIMIT && lo <= LBA28_LIMIT) begin
                hi = LBA28_LIMIT;
            end
            r.start_sector = pick_between(lo, hi);
        end else begin
            r.start_sector = ($urandom_range(0, 1) == 1) ? rand48()
                                                         : LBA_W'($urandom_range(0, 1000));
        end
        return r;
    endfunction

    function automatic int sender_gap();
        if (tail_mode) begin
            return 0;
        end
        if ($urandom_range(0, 3) == 0) begin
            return int'($urandom_range(1, 12));
        end
        return 0;
    endfunction

    task automatic drive_req(input atacs_pkg::t_req r, input logic typed,
                             input atacs_pkg::t_outcome oc, input int gap);
        i_req_valid <= 1'b1;
        i_req       <= r;
        @(posedge i_clk);
        while (!o_req_ready) @(posedge i_clk);
        if (typed) begin
            queue_write(atacs_pkg::REG_NONE, 8'h00, 1'b0, oc, 1'b1);
        end else begin
            predict_taskfile(r);
        end
        req_count++;
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_req_valid <= 1'b0;
        while (expected_tf_writes.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input atacs_pkg::t_cfg_idx idx, input logic [LBA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_cfg(input t_cfg c);
        wait_drained();
        write_reg(atacs_pkg::CFG_DEVICE_PRESENT,  {{(LBA_W-1){1'b0}}, c.present});
        write_reg(atacs_pkg::CFG_LONG_ADDRESSING, {{(LBA_W-1){1'b0}}, c.long_addr});
        write_reg(atacs_pkg::CFG_SECONDARY_DRIVE, {{(LBA_W-1){1'b0}}, c.secondary});
        write_reg(atacs_pkg::CFG_CAPACITY,        c.capacity);
        write_reg(atacs_pkg::CFG_PROTECTED_LIMIT, c.plimit);
        i_cfg_we <= 1'b0;
        cfg = c;
        cfg_count++;
    endtask

    initial begin : rx_side
        i_rsp_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                i_rsp_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
                i_rsp_ready <= 1'b1;
            end else if (!tail_mode && $urandom_range(0, 9) == 0) begin
                i_rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                i_rsp_ready <= 1'b1;
            end else begin
                i_rsp_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : word_check
        atacs_pkg::t_rsp want;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            word_count++;
            if (expected_tf_writes.size() == 0) begin
                note_error($sformatf("unexpected word: off=%0d val=%02h outcome=%0d last=%0b",
                                     o_rsp.reg_offset, o_rsp.reg_value, o_rsp.outcome,
                                     o_rsp.last));
            end else begin
                want = expected_tf_writes.pop_front();
                if (o_rsp.reg_offset !== want.reg_offset || o_rsp.reg_value !== want.reg_value
                    || o_rsp.settle_after !== want.settle_after
                    || o_rsp.outcome !== want.outcome || o_rsp.last !== want.last) begin
                    note_error($sformatf(
                        "mismatch: exp off=%0d val=%02h settle=%0b outcome=%0d last=%0b, got off=%0d val=%02h settle=%0b outcome=%0d last=%0b",
                        want.reg_offset, want.reg_value, want.settle_after, want.outcome,
                        want.last, o_rsp.reg_offset, o_rsp.reg_value, o_rsp.settle_after,
                        o_rsp.outcome, o_rsp.last));
                end
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready) || i_cfg_we) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("ata_taskfile_command_setup_unit_tb failed");
        $finish;
    end

    initial begin : stimulus
        int   ph;
        int   k;
        logic [2:0] cur_phase;
        t_cfg c;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_wdata = '0;
        i_req_valid = 1'b0;
        i_req       = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cur_phase = 3'd0;
        for (k = 0; k < NUM_DIR; k++) begin
            if (DIR_ROWS[k].phase != cur_phase) begin
                cur_phase = DIR_ROWS[k].phase;
                apply_cfg(DIR_CFG[cur_phase]);
            end
            drive_req(DIR_ROWS[k].req, DIR_ROWS[k].typed, DIR_ROWS[k].outcome, sender_gap());
        end

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            c = rand_cfg();
            if (ph == HOLD_PHASE) begin
                c.present   = 1'b1;
                c.long_addr = 1'b1;
                c.capacity  = LBA_MAX;
                c.plimit    = '0;
            end
            apply_cfg(c);
            if (ph == RAND_PHASES - 1) begin
                tail_mode = 1'b1;
            end
            if (ph == HOLD_PHASE) begin
                rx_hold_req = 1'b1;
            end
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (ph == PAUSE_PHASE && k == ITEMS_PER_PHASE / 2) begin
                    wait_drained();
                end
                drive_req(rand_req(), 1'b0, atacs_pkg::OUT_OK,
                          (ph == HOLD_PHASE) ? 0 : sender_gap());
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("summary: %0d requests under %0d register settings, %0d taskfile words checked",
                 req_count, cfg_count, word_count);
        $display("summary: corner rows, a %0d-cycle receiver hold-off and a drained pause ran",
                 RX_HOLD_CYCLES);
        if (err_count == 0) begin
            $display("ata_taskfile_command_setup_unit_tb passed");
        end else begin
            $display("ata_taskfile_command_setup_unit_tb failed");
        end
        $finish;
    end

endmodule

// ===== ata_taskfile_command_setup_unit.f =====
+incdir+design
design/atacs_pkg.sv
design/ata_taskfile_command_setup_unit.sv
design/atacs_checker.sv
test/ata_taskfile_command_setup_unit_tb.sv
